// ----- rtl/pgt_pkg.sv -----
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared constants, payload bundles and wide-multiply helpers for the polar
// Gaussian transform pipeline.
// ----------------------------------------------------------------------------
package pgt_pkg;

    localparam int LOG_FRAC    = 48;   // fraction bits of the log2 result
    localparam int SQRT_STEPS  = 56;   // root bits produced by the square root
    localparam int RATIO_BITS  = 32;   // bits of the coordinate ratio
    localparam int TOP_W       = 7;    // width of a leading-one index

    // 2 ln 2 in Q1.62, rounded to nearest
    localparam logic [63:0] TWO_LN2_Q62 = 64'h58B90BFBE8E7BCD6;

    // four 32x32 partial products of a 64x64 multiply
    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } pp_t;

    // per-word data carried alongside the log and root stages
    typedef struct packed {
        logic             fneg;
        logic             sneg;
        logic [TOP_W-1:0] top;
        logic [63:0]      rn;
        logic [31:0]      hn_first;
        logic [31:0]      hn_second;
    } side_t;

    // one lane of the ratio search: c, c*c*rn and c*rn
    typedef struct packed {
        logic [31:0]  c;
        logic [127:0] p;
        logic [95:0]  q;
    } lane_t;

    // form the partial products; the sum happens a stage later
    function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
        pp_t r;
        r.ll = 64'(a[31:0])  * 64'(b[31:0]);
        r.lh = 64'(a[31:0])  * 64'(b[63:32]);
        r.hl = 64'(a[63:32]) * 64'(b[31:0]);
        r.hh = 64'(a[63:32]) * 64'(b[63:32]);
        return r;
    endfunction

    // add the partial products into the full 128-bit product
    function automatic logic [127:0] pp_sum(input pp_t p);
        return 128'(p.ll) + (128'(p.lh) << 32) + (128'(p.hl) << 32) + (128'(p.hh) << 64);
    endfunction

endpackage

// ----- rtl/polar_gaussian_transform.sv -----
// ----------------------------------------------------------------------------
// polar_gaussian_transform
// Fixed-point polar Box-Muller transform: one uniform pair in, zero or one
// pair of standard normal samples out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive u_first/u_second (unsigned Q0.UNIFORM_BITS) and
//   raise start; the word is taken at every rising edge with start high and
//   busy low. busy stays low, so a new pair may enter on every cycle.
//   Output channel: done pulses for one cycle with gauss_first/gauss_second
//   (signed Q.OUT_FRAC_BITS). The receiver must take the word in that cycle.
//   Pairs outside the unit circle, or at its center, produce no word.
// Order: results leave in input order. The depth is 48 log2 squaring
//   steps at two stages each, 56 square-root digit stages, 32 ratio-search
//   stages and eleven setup and output stages, each stage one wide add or
//   one set of 32x32 partial products.
// Throughput: one pair per cycle; every stage is registered and nothing
//   stalls.
// Reset: clears all valid bits; words in flight are dropped. No memories,
//   so no clearing pass is needed.
// ----------------------------------------------------------------------------
module polar_gaussian_transform #(
    parameter int UNIFORM_BITS  = 32,
    parameter int OUT_FRAC_BITS = 26
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [UNIFORM_BITS-1:0] u_first,
    input  logic [UNIFORM_BITS-1:0] u_second,
    output logic                    done,
    output logic signed [31:0]      gauss_first,
    output logic signed [31:0]      gauss_second
);

    localparam int UW       = UNIFORM_BITS;
    localparam int RW       = 2 * UW;
    localparam int TW       = pgt_pkg::TOP_W;
    localparam int LOG_FRAC = pgt_pkg::LOG_FRAC;
    localparam int SQ_STEPS = pgt_pkg::SQRT_STEPS;
    localparam int CS_STEPS = pgt_pkg::RATIO_BITS;
    localparam int SH       = 31 + 48 - OUT_FRAC_BITS;
    localparam int LAT      = 5 + 2 * LOG_FRAC + 3 + SQ_STEPS + 1 + CS_STEPS + 2;
    localparam logic [UW-1:0]  HALF    = {1'b1, {(UW-1){1'b0}}};
    localparam logic [TW-1:0]  LIM_TOP = TW'(2 * UW - 2);
    localparam logic [127:0]   ROUND   = 128'(1) << (SH - 1);

    // never hold off the sender
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage A: center the uniforms, split sign and magnitude
    // ------------------------------------------------------------------
    logic          a_valid_reg;
    logic [UW-1:0] a_h_reg, a_k_reg, a_h_next, a_k_next;
    logic          a_hneg_reg, a_kneg_reg;

    always_comb
    begin
        a_h_next = (u_first  < HALF) ? HALF - u_first  : u_first  - HALF;
        a_k_next = (u_second < HALF) ? HALF - u_second : u_second - HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        a_h_reg    <= a_h_next;
        a_k_reg    <= a_k_next;
        a_hneg_reg <= u_first  < HALF;
        a_kneg_reg <= u_second < HALF;
    end

    // ------------------------------------------------------------------
    // Stage B: square partial products
    // ------------------------------------------------------------------
    logic           b_valid_reg;
    pgt_pkg::pp_t   b_pph_reg, b_ppk_reg;
    logic [UW-1:0]  b_h_reg, b_k_reg;
    logic           b_hneg_reg, b_kneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_pph_reg  <= pgt_pkg::pp_mul(64'(a_h_reg), 64'(a_h_reg));
        b_ppk_reg  <= pgt_pkg::pp_mul(64'(a_k_reg), 64'(a_k_reg));
        b_h_reg    <= a_h_reg;
        b_k_reg    <= a_k_reg;
        b_hneg_reg <= a_hneg_reg;
        b_kneg_reg <= a_kneg_reg;
    end

    // ------------------------------------------------------------------
    // Stage C: radius squared R = h*h + k*k
    // ------------------------------------------------------------------
    logic          c_valid_reg;
    logic [RW-1:0] c_r_reg, c_r_next;
    logic [UW-1:0] c_h_reg, c_k_reg;
    logic          c_hneg_reg, c_kneg_reg;

    assign c_r_next = RW'(pgt_pkg::pp_sum(b_pph_reg) + pgt_pkg::pp_sum(b_ppk_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        c_r_reg    <= c_r_next;
        c_h_reg    <= b_h_reg;
        c_k_reg    <= b_k_reg;
        c_hneg_reg <= b_hneg_reg;
        c_kneg_reg <= b_kneg_reg;
    end

    // ------------------------------------------------------------------
    // Stage D: leading one of R; drop zero radius and points outside
    // ------------------------------------------------------------------
    logic          d_valid_reg;
    logic [TW-1:0] d_top_reg, d_top_next;
    logic          d_keep;
    logic [RW-1:0] d_r_reg;
    logic [UW-1:0] d_h_reg, d_k_reg;
    logic          d_hneg_reg, d_kneg_reg;

    always_comb
    begin
        d_top_next = '0;
        for (int i = 0; i < RW; i++)
        begin
            if (c_r_reg[i])
                d_top_next = TW'(i);
        end
        d_keep = (|c_r_reg) && (d_top_next < LIM_TOP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else
            d_valid_reg <= c_valid_reg && d_keep;
    end

    always_ff @(posedge clk)
    begin
        d_top_reg  <= d_top_next;
        d_r_reg    <= c_r_reg;
        d_h_reg    <= c_h_reg;
        d_k_reg    <= c_k_reg;
        d_hneg_reg <= c_hneg_reg;
        d_kneg_reg <= c_kneg_reg;
    end

    // ------------------------------------------------------------------
    // Stage E: normalize R for the log, scale R and h, k by an even power
    // ------------------------------------------------------------------
    logic [RW+61:0]  e_wide;
    logic [UW+30:0]  e_hwide, e_kwide;
    logic [TW-1:0]   e_rn_sh, e_hn_sh;
    pgt_pkg::side_t  e_side_next;
    logic [63:0]     e_z_next;

    logic [63:0]          lg_z_reg    [0:LOG_FRAC];
    logic [LOG_FRAC-1:0]  lg_f_reg    [0:LOG_FRAC];
    pgt_pkg::side_t       lg_side_reg [0:LOG_FRAC];
    logic                 lg_valid_reg[0:LOG_FRAC];

    always_comb
    begin
        e_wide   = {d_r_reg, 62'b0};
        e_hwide  = {d_h_reg, 31'b0};
        e_kwide  = {d_k_reg, 31'b0};
        e_rn_sh  = (d_top_reg & ~TW'(1)) + TW'(2);
        e_hn_sh  = (d_top_reg >> 1) + TW'(1);
        e_z_next = 64'(e_wide >> d_top_reg);
        e_side_next.fneg      = d_hneg_reg;
        e_side_next.sneg      = d_kneg_reg;
        e_side_next.top       = d_top_reg;
        e_side_next.rn        = 64'(e_wide >> e_rn_sh);
        e_side_next.hn_first  = 32'(e_hwide >> e_hn_sh);
        e_side_next.hn_second = 32'(e_kwide >> e_hn_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lg_valid_reg[0] <= 1'b0;
        else
            lg_valid_reg[0] <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        lg_z_reg[0]    <= e_z_next;
        lg_f_reg[0]    <= '0;
        lg_side_reg[0] <= e_side_next;
    end

    // ------------------------------------------------------------------
    // log2 of the mantissa: square, renormalize, emit one bit per step
    // ------------------------------------------------------------------
    pgt_pkg::pp_t         lm_pp_reg   [0:LOG_FRAC-1];
    logic [LOG_FRAC-1:0]  lm_f_reg    [0:LOG_FRAC-1];
    pgt_pkg::side_t       lm_side_reg [0:LOG_FRAC-1];
    logic                 lm_valid_reg[0:LOG_FRAC-1];

    for (genvar j = 0; j < LOG_FRAC; j++)
    begin : g_log
        logic [127:0]         sq_w;
        logic [63:0]          z2;
        logic [63:0]          z_next;
        logic [LOG_FRAC-1:0]  f_next;

        always_comb
        begin
            sq_w   = pgt_pkg::pp_sum(lm_pp_reg[j]);
            z2     = sq_w[125:62];
            z_next = z2[63] ? {1'b0, z2[63:1]} : z2;
            f_next = {lm_f_reg[j][LOG_FRAC-2:0], z2[63]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lm_valid_reg[j]   <= 1'b0;
                lg_valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                lm_valid_reg[j]   <= lg_valid_reg[j];
                lg_valid_reg[j+1] <= lm_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            lm_pp_reg[j]     <= pgt_pkg::pp_mul(lg_z_reg[j], lg_z_reg[j]);
            lm_f_reg[j]      <= lg_f_reg[j];
            lm_side_reg[j]   <= lg_side_reg[j];
            lg_z_reg[j+1]    <= z_next;
            lg_f_reg[j+1]    <= f_next;
            lg_side_reg[j+1] <= lm_side_reg[j];
        end
    end

    // ------------------------------------------------------------------
    // Stage M: -log2 r2 in Q.48
    // ------------------------------------------------------------------
    logic           m_valid_reg;
    logic [63:0]    m_lval_reg, m_lval_next;
    pgt_pkg::side_t m_side_reg;

    assign m_lval_next = (64'(LIM_TOP - lg_side_reg[LOG_FRAC].top) << LOG_FRAC)
                         - 64'(lg_f_reg[LOG_FRAC]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= lg_valid_reg[LOG_FRAC];
    end

    always_ff @(posedge clk)
    begin
        m_lval_reg <= m_lval_next;
        m_side_reg <= lg_side_reg[LOG_FRAC];
    end

    // ------------------------------------------------------------------
    // Stage N: scale by 2 ln 2 (partial products)
    // ------------------------------------------------------------------
    logic           n_valid_reg;
    pgt_pkg::pp_t   n_pp_reg;
    pgt_pkg::side_t n_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else
            n_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        n_pp_reg   <= pgt_pkg::pp_mul(m_lval_reg, pgt_pkg::TWO_LN2_Q62);
        n_side_reg <= m_side_reg;
    end

    // ------------------------------------------------------------------
    // Stage O: q = -2 ln r2 in Q.48, seeds the square root
    // ------------------------------------------------------------------
    logic [63:0]    sq_q_reg    [0:SQ_STEPS];
    logic [59:0]    sq_rem_reg  [0:SQ_STEPS];
    logic [55:0]    sq_root_reg [0:SQ_STEPS];
    pgt_pkg::side_t sq_side_reg [0:SQ_STEPS];
    logic           sq_valid_reg[0:SQ_STEPS];
    logic [63:0]    o_q_next;

    assign o_q_next = 64'(pgt_pkg::pp_sum(n_pp_reg) >> 62);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else
            sq_valid_reg[0] <= n_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        sq_q_reg[0]    <= o_q_next;
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        sq_side_reg[0] <= n_side_reg;
    end

    // ------------------------------------------------------------------
    // Square root of q * 2^48, one root bit per stage
    // ------------------------------------------------------------------
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        logic [111:0] v;
        logic [59:0]  remx;
        logic [59:0]  trial;
        logic         take;

        always_comb
        begin
            v     = {sq_q_reg[i], 48'b0};
            remx  = {sq_rem_reg[i][57:0], v[111-2*i -: 2]};
            trial = 60'({sq_root_reg[i], 2'b01});
            take  = remx >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[i+1] <= 1'b0;
            else
                sq_valid_reg[i+1] <= sq_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            sq_q_reg[i+1]    <= sq_q_reg[i];
            sq_side_reg[i+1] <= sq_side_reg[i];
            sq_rem_reg[i+1]  <= take ? remx - trial : remx;
            sq_root_reg[i+1] <= {sq_root_reg[i][54:0], take};
        end
    end

    // ------------------------------------------------------------------
    // Stage H: square the scaled coordinates, seed the ratio search
    // ------------------------------------------------------------------
    logic [63:0]     cs_hsq_reg  [0:CS_STEPS][0:1];
    pgt_pkg::lane_t  cs_lane_reg [0:CS_STEPS][0:1];
    logic [63:0]     cs_rn_reg   [0:CS_STEPS];
    logic [55:0]     cs_s_reg    [0:CS_STEPS];
    logic            cs_fneg_reg [0:CS_STEPS];
    logic            cs_sneg_reg [0:CS_STEPS];
    logic            cs_valid_reg[0:CS_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cs_valid_reg[0] <= 1'b0;
        else
            cs_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        cs_hsq_reg[0][0]  <= 64'(sq_side_reg[SQ_STEPS].hn_first)
                             * 64'(sq_side_reg[SQ_STEPS].hn_first);
        cs_hsq_reg[0][1]  <= 64'(sq_side_reg[SQ_STEPS].hn_second)
                             * 64'(sq_side_reg[SQ_STEPS].hn_second);
        cs_lane_reg[0][0] <= '0;
        cs_lane_reg[0][1] <= '0;
        cs_rn_reg[0]      <= sq_side_reg[SQ_STEPS].rn;
        cs_s_reg[0]       <= sq_root_reg[SQ_STEPS];
        cs_fneg_reg[0]    <= sq_side_reg[SQ_STEPS].fneg;
        cs_sneg_reg[0]    <= sq_side_reg[SQ_STEPS].sneg;
    end

    // ------------------------------------------------------------------
    // Ratio search: largest c with c*c*rn <= hn*hn*2^62, one bit per stage,
    // c*c*rn kept up to date by shifts and adds
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CS_STEPS; i++)
    begin : g_ratio
        localparam int B = CS_STEPS - 1 - i;
        logic [127:0]    p_try  [0:1];
        logic [127:0]    target [0:1];
        pgt_pkg::lane_t  lane_nx[0:1];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                target[l]  = {2'b0, cs_hsq_reg[i][l], 62'b0};
                p_try[l]   = cs_lane_reg[i][l].p
                             + (128'(cs_lane_reg[i][l].q) << (B + 1))
                             + (128'(cs_rn_reg[i]) << (2 * B));
                lane_nx[l] = cs_lane_reg[i][l];
                if (p_try[l] <= target[l])
                begin
                    lane_nx[l].c = cs_lane_reg[i][l].c | (32'(1) << B);
                    lane_nx[l].p = p_try[l];
                    lane_nx[l].q = cs_lane_reg[i][l].q + (96'(cs_rn_reg[i]) << B);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cs_valid_reg[i+1] <= 1'b0;
            else
                cs_valid_reg[i+1] <= cs_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            cs_hsq_reg[i+1][0]  <= cs_hsq_reg[i][0];
            cs_hsq_reg[i+1][1]  <= cs_hsq_reg[i][1];
            cs_lane_reg[i+1][0] <= lane_nx[0];
            cs_lane_reg[i+1][1] <= lane_nx[1];
            cs_rn_reg[i+1]      <= cs_rn_reg[i];
            cs_s_reg[i+1]       <= cs_s_reg[i];
            cs_fneg_reg[i+1]    <= cs_fneg_reg[i];
            cs_sneg_reg[i+1]    <= cs_sneg_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage F1: c * s partial products
    // ------------------------------------------------------------------
    logic          f1_valid_reg;
    pgt_pkg::pp_t  f1_pp_reg [0:1];
    logic          f1_fneg_reg, f1_sneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= cs_valid_reg[CS_STEPS];
    end

    always_ff @(posedge clk)
    begin
        f1_pp_reg[0] <= pgt_pkg::pp_mul(64'(cs_lane_reg[CS_STEPS][0].c),
                                        64'(cs_s_reg[CS_STEPS]));
        f1_pp_reg[1] <= pgt_pkg::pp_mul(64'(cs_lane_reg[CS_STEPS][1].c),
                                        64'(cs_s_reg[CS_STEPS]));
        f1_fneg_reg  <= cs_fneg_reg[CS_STEPS];
        f1_sneg_reg  <= cs_sneg_reg[CS_STEPS];
    end

    // ------------------------------------------------------------------
    // Stage F2: round, saturate, apply sign, drive the result word
    // ------------------------------------------------------------------
    logic        done_reg;
    logic [31:0] gauss_first_reg, gauss_second_reg;
    logic [31:0] gauss_next [0:1];
    logic [127:0] f2_mag [0:1];
    logic [31:0]  f2_lim [0:1];
    logic         f2_neg [0:1];

    always_comb
    begin
        f2_neg[0] = f1_fneg_reg;
        f2_neg[1] = f1_sneg_reg;
        for (int l = 0; l < 2; l++)
        begin
            f2_mag[l] = (pgt_pkg::pp_sum(f1_pp_reg[l]) + ROUND) >> SH;
            if (f2_neg[l])
            begin
                f2_lim[l] = ((|f2_mag[l][127:32]) || (f2_mag[l][31:0] > 32'h80000000))
                            ? 32'h80000000 : f2_mag[l][31:0];
                gauss_next[l] = 32'd0 - f2_lim[l];
            end
            else
            begin
                f2_lim[l] = (|f2_mag[l][127:31]) ? 32'h7FFFFFFF : f2_mag[l][31:0];
                gauss_next[l] = f2_lim[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        gauss_first_reg  <= gauss_next[0];
        gauss_second_reg <= gauss_next[1];
    end

    assign done         = done_reg;
    assign gauss_first  = gauss_first_reg;
    assign gauss_second = gauss_second_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result word without an accepted pair at the pipeline depth");

    a_kept_inside: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (d_top_reg < LIM_TOP))
        else $error("pair outside the unit circle was kept");

    a_log_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        lg_valid_reg[LOG_FRAC] |-> (lg_z_reg[LOG_FRAC][63:62] == 2'b01))
        else $error("log mantissa left its normalized range");

endmodule
